@@ hw/rtl/pbd_pkg.sv @@
// Shared constants, tables and payload types of the bearing and distance block.
`default_nettype none

package pbd_pkg;

  // Field formats
  localparam int COORD_WIDTH     = 16;
  localparam int ANGLE_FRAC_BITS = 7;
  localparam int DIST_FRAC_BITS  = 4;
  localparam int BEARING_W       = 16;
  localparam int DIST_W          = 21;

  // CORDIC vectoring datapath
  localparam int CORDIC_STEPS = 24;
  localparam int TABLE_FRAC   = 24;
  localparam int PRE_SHIFT    = 58 - COORD_WIDTH;
  localparam int XY_W         = 62;
  localparam int Z_W          = 33;
  localparam int ANG_A_W      = 7 + ANGLE_FRAC_BITS;   // first-quadrant angle, up to 90 deg
  localparam int ANG_W        = 9 + ANGLE_FRAC_BITS;   // full-turn angle, below 360 deg

  // Square root datapath
  localparam int SUM_W      = 2 * COORD_WIDTH + 1 + 2 * DIST_FRAC_BITS;
  localparam int SQRT_STEPS = (SUM_W + 1) / 2;
  localparam int SQ_W       = 2 * SQRT_STEPS;

  // Pipeline depths, measured from the input register
  localparam int CORDIC_LAT = CORDIC_STEPS + 1;
  localparam int DIST_LAT   = SQRT_STEPS + 3;
  localparam int PATH_LAT   = (CORDIC_LAT > DIST_LAT) ? CORDIC_LAT : DIST_LAT;

  // atan(2^-i) in degrees, scaled by 2^24 and rounded
  localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938, 32'd60000934,
    32'd30029717,  32'd15018523,  32'd7509720,   32'd3754917,   32'd1877466,
    32'd938734,    32'd469367,    32'd234684,    32'd117342,    32'd58671,
    32'd29335,     32'd14668,     32'd7334,      32'd3667,      32'd1833,
    32'd917,       32'd458,       32'd229,       32'd115
  };

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] from_x;
    logic signed [COORD_WIDTH-1:0] from_y;
    logic signed [COORD_WIDTH-1:0] to_x;
    logic signed [COORD_WIDTH-1:0] to_y;
  } pt_pair_t;

  typedef struct packed {
    logic [BEARING_W-1:0] bearing;
    logic [DIST_W-1:0]    distance;
  } bearing_dist_t;

  // Sign information of the difference vector, carried alongside the datapaths
  typedef struct packed {
    logic dx_zero;
    logic dx_neg;
    logic dy_zero;
    logic dy_neg;
  } quad_flags_t;

endpackage

`default_nettype wire

@@ hw/rtl/pbd_delay.sv @@
// Fixed-depth register delay line for sideband data.
`default_nettype none

module pbd_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] line [DEPTH];

  // Shift one place per cycle
  always_ff @(posedge clk) begin
    line[0] <= din;
    for (int k = 1; k < DEPTH; k++) begin
      line[k] <= line[k-1];
    end
  end

  assign dout = line[DEPTH-1];

endmodule

`default_nettype wire

@@ hw/rtl/pbd_cordic.sv @@
// Pipelined CORDIC in vectoring mode: first-quadrant angle of (ax, ay) in degrees.
`default_nettype none

module pbd_cordic (
  input  logic                           clk,
  input  logic [pbd_pkg::COORD_WIDTH-1:0] ax,
  input  logic [pbd_pkg::COORD_WIDTH-1:0] ay,
  output logic [pbd_pkg::ANG_A_W-1:0]     angle
);
  import pbd_pkg::*;

  localparam int DROP = TABLE_FRAC - ANGLE_FRAC_BITS;
  localparam logic signed [Z_W-1:0] RND_HALF = Z_W'(1) <<< (DROP - 1);
  localparam logic signed [Z_W-1:0] FULL_Q   = Z_W'(90 << ANGLE_FRAC_BITS);

  logic signed [XY_W-1:0] x_q [CORDIC_STEPS];
  logic signed [XY_W-1:0] y_q [CORDIC_STEPS];
  logic signed [Z_W-1:0]  z_q [CORDIC_STEPS];

  logic [XY_W-1:0] ax_ext;
  logic [XY_W-1:0] ay_ext;

  // Scale the magnitudes up to the working precision
  assign ax_ext = XY_W'(ax) << PRE_SHIFT;
  assign ay_ext = XY_W'(ay) << PRE_SHIFT;

  // One micro-rotation per stage
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    localparam logic signed [Z_W-1:0] ATAN_I = signed'({1'b0, ATAN_TAB[i]});
    logic signed [XY_W-1:0] x_in;
    logic signed [XY_W-1:0] y_in;
    logic signed [Z_W-1:0]  z_in;
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    logic                   y_pos;

    if (i == 0) begin : g_first
      assign x_in = signed'(ax_ext);
      assign y_in = signed'(ay_ext);
      assign z_in = '0;
    end else begin : g_next
      assign x_in = x_q[i-1];
      assign y_in = y_q[i-1];
      assign z_in = z_q[i-1];
    end

    assign xs    = x_in >>> i;
    assign ys    = y_in >>> i;
    assign y_pos = !y_in[XY_W-1] && (y_in != '0);

    always_ff @(posedge clk) begin
      if (y_pos) begin
        x_q[i] <= x_in + ys;
        y_q[i] <= y_in - xs;
        z_q[i] <= z_in + ATAN_I;
      end else begin
        x_q[i] <= x_in - ys;
        y_q[i] <= y_in + xs;
        z_q[i] <= z_in - ATAN_I;
      end
    end
  end

  logic signed [Z_W-1:0] z_rnd;
  logic signed [Z_W-1:0] q;

  // Round half up to the output resolution, then clamp to [0, 90] degrees
  assign z_rnd = z_q[CORDIC_STEPS-1] + RND_HALF;
  assign q     = z_rnd >>> DROP;

  always_ff @(posedge clk) begin
    if (q[Z_W-1]) begin
      angle <= '0;
    end else if (q > FULL_Q) begin
      angle <= FULL_Q[ANG_A_W-1:0];
    end else begin
      angle <= q[ANG_A_W-1:0];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/pbd_dist.sv @@
// Pipelined distance unit: sum of squares and a rounded integer square root.
`default_nettype none

module pbd_dist (
  input  logic                           clk,
  input  logic [pbd_pkg::COORD_WIDTH-1:0] ax,
  input  logic [pbd_pkg::COORD_WIDTH-1:0] ay,
  output logic [pbd_pkg::DIST_W-1:0]      distance
);
  import pbd_pkg::*;

  logic [2*COORD_WIDTH-1:0] ax_sq;
  logic [2*COORD_WIDTH-1:0] ay_sq;
  logic [SQ_W-1:0]          n_init;

  // Squares, then their sum scaled by the fraction bits
  always_ff @(posedge clk) begin
    ax_sq  <= ax * ax;
    ay_sq  <= ay * ay;
    n_init <= SQ_W'({1'b0, ax_sq} + {1'b0, ay_sq}) << (2 * DIST_FRAC_BITS);
  end

  logic [SQ_W-1:0] n_q [SQRT_STEPS];
  logic [SQ_W-1:0] r_q [SQRT_STEPS];

  // One result bit per stage, most significant first
  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_root
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQRT_STEPS - 1 - j));
    logic [SQ_W-1:0] n_in;
    logic [SQ_W-1:0] r_in;
    logic [SQ_W:0]   trial;

    if (j == 0) begin : g_first
      assign n_in = n_init;
      assign r_in = '0;
    end else begin : g_next
      assign n_in = n_q[j-1];
      assign r_in = r_q[j-1];
    end

    assign trial = {1'b0, r_in} + {1'b0, BIT};

    always_ff @(posedge clk) begin
      if ({1'b0, n_in} >= trial) begin
        n_q[j] <= n_in - trial[SQ_W-1:0];
        r_q[j] <= (r_in >> 1) + BIT;
      end else begin
        n_q[j] <= n_in;
        r_q[j] <= r_in >> 1;
      end
    end
  end

  logic [SQRT_STEPS-1:0] root;
  logic                  round_up;
  logic [SQRT_STEPS:0]   root_rnd;

  // Round to nearest: the remainder exceeds the root past the midpoint
  assign root     = r_q[SQRT_STEPS-1][SQRT_STEPS-1:0];
  assign round_up = n_q[SQRT_STEPS-1] > r_q[SQRT_STEPS-1];
  assign root_rnd = {1'b0, root} + (SQRT_STEPS + 1)'(round_up);

  always_ff @(posedge clk) begin
    distance <= DIST_W'(root_rnd);
  end

endmodule

`default_nettype wire

@@ hw/rtl/point_bearing_and_distance.sv @@
// Top level: bearing and distance between two points, fully pipelined.
//
// Usage: drive the two points on operands and pulse start; a transfer takes
// place at every rising edge with start high and busy low. busy is always
// low, so a new point pair may be given in every cycle.
// Each transfer yields one result: done is high for exactly one cycle with
// result.bearing (degrees x 128, 0 to below 360) and result.distance
// (distance x 16, rounded). Results leave in the order the pairs came in.
// The depth from the transfer to done is set by the 24-stage CORDIC angle
// pipeline plus its rounding stage, with the input and output registers
// around it. The square root pipeline runs alongside and is padded to the
// same depth.
// Throughput: one pair per cycle.
// Reset (rst, synchronous) clears the valid pipeline; pairs in flight are
// dropped. The receiver cannot stall: a result must be taken in its cycle.
`default_nettype none

module point_bearing_and_distance (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  pbd_pkg::pt_pair_t      operands,
  output logic                   done,
  output pbd_pkg::bearing_dist_t result
);
  import pbd_pkg::*;

  localparam int CORDIC_PAD = PATH_LAT - CORDIC_LAT;
  localparam int DIST_PAD   = PATH_LAT - DIST_LAT;

  localparam logic [ANG_W-1:0] DEG90  = ANG_W'(90 << ANGLE_FRAC_BITS);
  localparam logic [ANG_W-1:0] DEG180 = ANG_W'(180 << ANGLE_FRAC_BITS);
  localparam logic [ANG_W-1:0] DEG270 = ANG_W'(270 << ANGLE_FRAC_BITS);
  localparam logic [ANG_W-1:0] DEG360 = ANG_W'(360 << ANGLE_FRAC_BITS);

  assign busy = 1'b0;

  // Difference vector and its magnitudes
  logic signed [COORD_WIDTH:0] dx;
  logic signed [COORD_WIDTH:0] dy;
  logic [COORD_WIDTH:0]        dx_mag;
  logic [COORD_WIDTH:0]        dy_mag;
  quad_flags_t                 flags_in;

  assign dx = signed'({operands.to_x[COORD_WIDTH-1], operands.to_x})
            - signed'({operands.from_x[COORD_WIDTH-1], operands.from_x});
  assign dy = signed'({operands.to_y[COORD_WIDTH-1], operands.to_y})
            - signed'({operands.from_y[COORD_WIDTH-1], operands.from_y});
  assign dx_mag = dx[COORD_WIDTH] ? unsigned'(-dx) : unsigned'(dx);
  assign dy_mag = dy[COORD_WIDTH] ? unsigned'(-dy) : unsigned'(dy);

  assign flags_in.dx_zero = (dx == '0);
  assign flags_in.dx_neg  = dx[COORD_WIDTH];
  assign flags_in.dy_zero = (dy == '0);
  assign flags_in.dy_neg  = dy[COORD_WIDTH];

  // Input register
  logic                   s1_valid;
  logic [COORD_WIDTH-1:0] s1_ax;
  logic [COORD_WIDTH-1:0] s1_ay;
  quad_flags_t            s1_flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
    s1_ax    <= dx_mag[COORD_WIDTH-1:0];
    s1_ay    <= dy_mag[COORD_WIDTH-1:0];
    s1_flags <= flags_in;
  end

  // Valid bits travel with the datapaths
  logic [PATH_LAT-1:0] vld_pipe;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_pipe <= '0;
    end else begin
      vld_pipe <= {vld_pipe[PATH_LAT-2:0], s1_valid};
    end
  end

  // Angle and distance datapaths
  logic [ANG_A_W-1:0] angle_raw;
  logic [ANG_A_W-1:0] angle_al;
  logic [DIST_W-1:0]  dist_raw;
  logic [DIST_W-1:0]  dist_al;
  quad_flags_t        flags_al;

  pbd_cordic u_cordic (
    .clk   (clk),
    .ax    (s1_ax),
    .ay    (s1_ay),
    .angle (angle_raw)
  );

  pbd_dist u_dist (
    .clk      (clk),
    .ax       (s1_ax),
    .ay       (s1_ay),
    .distance (dist_raw)
  );

  pbd_delay #(
    .WIDTH ($bits(quad_flags_t)),
    .DEPTH (PATH_LAT)
  ) u_flags_dly (
    .clk  (clk),
    .din  (s1_flags),
    .dout (flags_al)
  );

  // Pad the shorter datapath so both arrive together
  if (CORDIC_PAD > 0) begin : g_angle_pad
    pbd_delay #(
      .WIDTH (ANG_A_W),
      .DEPTH (CORDIC_PAD)
    ) u_angle_dly (
      .clk  (clk),
      .din  (angle_raw),
      .dout (angle_al)
    );
  end else begin : g_angle_direct
    assign angle_al = angle_raw;
  end

  if (DIST_PAD > 0) begin : g_dist_pad
    pbd_delay #(
      .WIDTH (DIST_W),
      .DEPTH (DIST_PAD)
    ) u_dist_dly (
      .clk  (clk),
      .din  (dist_raw),
      .dout (dist_al)
    );
  end else begin : g_dist_direct
    assign dist_al = dist_raw;
  end

  // Quadrant correction
  logic [ANG_W-1:0] a_ext;
  logic [ANG_W-1:0] bearing_next;

  assign a_ext = flags_al.dy_zero ? '0 : ANG_W'(angle_al);

  always_comb begin
    if (flags_al.dx_zero) begin
      if (flags_al.dy_zero) begin
        bearing_next = '0;
      end else if (flags_al.dy_neg) begin
        bearing_next = DEG270;
      end else begin
        bearing_next = DEG90;
      end
    end else if (!flags_al.dx_neg) begin
      if (!flags_al.dy_neg) begin
        bearing_next = a_ext;
      end else if (a_ext == '0) begin
        // full turn wraps to zero
        bearing_next = '0;
      end else begin
        bearing_next = DEG360 - a_ext;
      end
    end else if (flags_al.dy_neg) begin
      bearing_next = DEG180 + a_ext;
    end else begin
      bearing_next = DEG180 - a_ext;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld_pipe[PATH_LAT-1];
    end
    result.bearing  <= BEARING_W'(bearing_next);
    result.distance <= dist_al;
  end

endmodule

`default_nettype wire
